// ===== design/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int OP_W  = 2;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SH_RD,
        ST_SH_WR,
        ST_PUT,
        ST_GET,
        ST_DONE
    } state_t;

endpackage

// ===== design/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded list addressed by position: insert, remove, get and set, with
// entries moved one at a time through a single-port store.
// ----------------------------------------------------------------------------
//  channel  | direction | fields (lowest bit up)
//  s_       | in        | op[1:0], position[8:2], value[40:9]
//  m_       | out       | ok[0], read_value[32:1], count[39:33]
//
//  Insert and remove pass through a read and a write state for each entry
//  moved; get and set go through one access state, a failed request none.
//  Each moved entry costs a read and a write through the one store port.
//  aresetn clears the count and the handshake state; the store holds garbage
//  until written. One request at a time; the next is taken while a reply
//  still waits on m_tready.
// ----------------------------------------------------------------------------
module positional_list_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0]  s_tdata,   // op, position, value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ple_pkg::M_TDATA_W-1:0]  m_tdata    // ok, read_value, count
);

    ple_pkg::state_t state_reg, state_next;

    logic [ple_pkg::DATA_WIDTH-1:0] mem [ple_pkg::CAPACITY];
    logic [ple_pkg::DATA_WIDTH-1:0] rdata_reg;

    ple_pkg::op_t                 op_reg, op_next;
    logic [ple_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [ple_pkg::VAL_W-1:0]    val_reg, val_next;
    logic [ple_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [ple_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         ok_reg, ok_next;

    logic                         m_valid_reg, m_valid_next;
    logic                         m_ok_reg, m_ok_next;
    logic [ple_pkg::VAL_W-1:0]    m_rd_reg, m_rd_next;
    logic [ple_pkg::CNT_W-1:0]    m_count_reg, m_count_next;

    logic                         mem_we;
    logic                         mem_re;
    logic [ple_pkg::IDX_W-1:0]    mem_waddr;
    logic [ple_pkg::IDX_W-1:0]    mem_raddr;
    logic [ple_pkg::DATA_WIDTH-1:0] mem_wdata;

    logic                         s_accept;
    logic                         req_ok;
    logic                         is_insert;
    logic [ple_pkg::CNT_W-1:0]    idx_step;
    logic [ple_pkg::CNT_W-1:0]    cmp_idx;
    logic                         more;
    logic                         out_free;
    logic [ple_pkg::CMP_W-1:0]    pos_x;
    logic [ple_pkg::CMP_W-1:0]    cnt_x;
    logic [ple_pkg::CMP_W-1:0]    idx_x;

    assign s_tready = (state_reg == ple_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign is_insert = (op_reg == ple_pkg::OP_INSERT);
    assign pos_x     = ple_pkg::CMP_W'(pos_reg);
    assign cnt_x     = ple_pkg::CMP_W'(count_reg);

    always_comb begin
        case (op_reg)
            ple_pkg::OP_INSERT:
                req_ok = (pos_x <= cnt_x) &&
                         (count_reg != ple_pkg::CNT_W'(ple_pkg::CAPACITY));
            default:
                req_ok = (pos_x < cnt_x);
        endcase
    end

    // shared step and loop test
    assign idx_step = is_insert ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
    assign cmp_idx  = (state_reg == ple_pkg::ST_CHECK)
                    ? (is_insert ? count_reg : ple_pkg::CNT_W'(pos_reg))
                    : idx_step;
    assign idx_x    = ple_pkg::CMP_W'(cmp_idx);
    assign more     = is_insert ? (idx_x > pos_x) : ((idx_x + 1'b1) < cnt_x);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ple_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = ple_pkg::ST_CHECK;
                end
            end
            ple_pkg::ST_CHECK: begin
                if (!req_ok) begin
                    state_next = ple_pkg::ST_DONE;
                end else begin
                    case (op_reg)
                        ple_pkg::OP_INSERT:
                            state_next = more ? ple_pkg::ST_SH_RD : ple_pkg::ST_PUT;
                        ple_pkg::OP_REMOVE:
                            state_next = more ? ple_pkg::ST_SH_RD : ple_pkg::ST_DONE;
                        ple_pkg::OP_GET:
                            state_next = ple_pkg::ST_GET;
                        default:
                            state_next = ple_pkg::ST_PUT;
                    endcase
                end
            end
            ple_pkg::ST_SH_RD: begin
                state_next = ple_pkg::ST_SH_WR;
            end
            ple_pkg::ST_SH_WR: begin
                if (more) begin
                    state_next = ple_pkg::ST_SH_RD;
                end else if (is_insert) begin
                    state_next = ple_pkg::ST_PUT;
                end else begin
                    state_next = ple_pkg::ST_DONE;
                end
            end
            ple_pkg::ST_PUT: begin
                state_next = ple_pkg::ST_DONE;
            end
            ple_pkg::ST_GET: begin
                state_next = ple_pkg::ST_DONE;
            end
            ple_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ple_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_ok_next    = m_ok_reg;
        m_rd_next    = m_rd_reg;
        m_count_next = m_count_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = idx_reg[ple_pkg::IDX_W-1:0];
        mem_raddr    = idx_step[ple_pkg::IDX_W-1:0];
        mem_wdata    = rdata_reg;
        case (state_reg)
            ple_pkg::ST_IDLE: begin
                if (s_accept) begin
                    op_next  = ple_pkg::op_t'(s_tdata[ple_pkg::OP_W-1:0]);
                    pos_next = s_tdata[ple_pkg::OP_W +: ple_pkg::POS_W];
                    val_next = s_tdata[ple_pkg::OP_W + ple_pkg::POS_W +: ple_pkg::VAL_W];
                end
            end
            ple_pkg::ST_CHECK: begin
                ok_next  = req_ok;
                idx_next = cmp_idx;
                if (req_ok && (op_reg == ple_pkg::OP_REMOVE) && !more) begin
                    count_next = count_reg - 1'b1;
                end
            end
            ple_pkg::ST_SH_RD: begin
                mem_re = 1'b1;
            end
            ple_pkg::ST_SH_WR: begin
                mem_we   = 1'b1;
                idx_next = idx_step;
                if (!more && !is_insert) begin
                    count_next = count_reg - 1'b1;
                end
            end
            ple_pkg::ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[ple_pkg::IDX_W-1:0];
                mem_wdata = ple_pkg::DATA_WIDTH'(val_reg);
                if (is_insert) begin
                    count_next = count_reg + 1'b1;
                end
            end
            ple_pkg::ST_GET: begin
                mem_re    = 1'b1;
                mem_raddr = pos_reg[ple_pkg::IDX_W-1:0];
            end
            ple_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_count_next = count_reg;
                    m_rd_next    = (ok_reg && (op_reg == ple_pkg::OP_GET))
                                 ? ple_pkg::VAL_W'(signed'(rdata_reg))
                                 : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ple_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        m_ok_reg    <= m_ok_next;
        m_rd_reg    <= m_rd_next;
        m_count_reg <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ple_pkg::M_TDATA_W'({ple_pkg::POS_W'(m_count_reg), m_rd_reg, m_ok_reg});

endmodule

// ===== dv/tb_positional_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A short directed
// sequence covers an empty store, the list ends and out-of-range
// positions. Random traffic follows, alternating between filling, draining
// and mixed phases. An in-bench list model predicts each reply, and every
// reply is checked field by field. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;

    localparam int N_RANDOM    = 2000;
    localparam int STALL_PCT   = 23;
    localparam int CALM_LO     = 900;
    localparam int CALM_HI     = 1200;
    localparam int WATCHDOG    = 4000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic                      ok;
        logic [ple_pkg::VAL_W-1:0] rd;
        logic [ple_pkg::CNT_W-1:0] cnt;
    } reply_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ple_pkg::S_TDATA_W-1:0] s_tdata;    // op, position, value
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ple_pkg::M_TDATA_W-1:0] m_tdata;    // ok, read_value, count

    logic [ple_pkg::S_TDATA_W-1:0] pending [$];
    reply_t                        replies_due [$];

    logic [ple_pkg::DATA_WIDTH-1:0] list_mem [ple_pkg::CAPACITY];
    int                             list_len;
    int                             plan_len;

    bit s_held;
    int n_taken;
    int n_replies;
    int errors;
    int idle_cycles;
    int op_ok [4];
    int op_bad [4];
    int peak_len;
    int full_rejects;

    positional_list_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic reply_t apply_list_op(ple_pkg::op_t op,
                                             logic [ple_pkg::POS_W-1:0] pos,
                                             logic [ple_pkg::VAL_W-1:0] val);
        reply_t r;
        int     i;
        r = '0;
        case (op)
            ple_pkg::OP_INSERT: begin
                if (pos <= list_len && list_len < ple_pkg::CAPACITY) begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = val[ple_pkg::DATA_WIDTH-1:0];
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            ple_pkg::OP_REMOVE: begin
                if (pos < list_len) begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            ple_pkg::OP_GET: begin
                if (pos < list_len) begin
                    r.rd = ple_pkg::VAL_W'($signed(list_mem[pos]));
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (pos < list_len) begin
                    list_mem[pos] = val[ple_pkg::DATA_WIDTH-1:0];
                    r.ok = 1'b1;
                end
            end
        endcase
        r.cnt = ple_pkg::CNT_W'(list_len);
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        errors++;
        $display("%0t ns  mismatch: %s", $realtime, msg);
    endtask

    // plan_len tracks the list length as the requests will leave it
    task automatic queue_request(ple_pkg::op_t op, logic [ple_pkg::POS_W-1:0] pos,
                                 logic [ple_pkg::VAL_W-1:0] val);
        logic [ple_pkg::S_TDATA_W-1:0] w;
        w = '0;
        w[ple_pkg::OP_W-1:0] = op;
        w[ple_pkg::OP_W +: ple_pkg::POS_W] = pos;
        w[ple_pkg::OP_W + ple_pkg::POS_W +: ple_pkg::VAL_W] = val;
        pending.push_back(w);
        if (op == ple_pkg::OP_INSERT && pos <= plan_len && plan_len < ple_pkg::CAPACITY)
            plan_len++;
        else if (op == ple_pkg::OP_REMOVE && pos < plan_len)
            plan_len--;
    endtask

    function automatic logic [ple_pkg::POS_W-1:0] pick_position(ple_pkg::op_t op);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = (op == ple_pkg::OP_INSERT) ? plan_len : plan_len - 1;
        if (roll < 85 && top >= 0)
            return ple_pkg::POS_W'($urandom_range(0, top));
        else if (roll < 95)
            return ple_pkg::POS_W'(plan_len + $urandom_range(0, 1));
        return ple_pkg::POS_W'($urandom_range(0, (1 << ple_pkg::POS_W) - 1));
    endfunction

    function automatic logic [ple_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(ple_pkg::VAL_W-1){1'b0}}};
            3:       return {1'b0, {(ple_pkg::VAL_W-1){1'b1}}};
            default: return ple_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // request side and m_tready: valid is held until taken, gaps only between requests
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_held) begin
                if (pending.size() > 0 &&
                    ((n_taken >= CALM_LO && n_taken < CALM_HI) ||
                     $urandom_range(0, 99) >= STALL_PCT)) begin
                    s_tdata  <= pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_held    = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= (n_taken >= CALM_LO && n_taken < CALM_HI) ||
                        ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    always @(posedge aclk) begin
        reply_t       exp_r;
        reply_t       got_r;
        ple_pkg::op_t op;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                op = ple_pkg::op_t'(s_tdata[ple_pkg::OP_W-1:0]);
                if (op == ple_pkg::OP_INSERT && list_len == ple_pkg::CAPACITY)
                    full_rejects++;
                exp_r = apply_list_op(op, s_tdata[ple_pkg::OP_W +: ple_pkg::POS_W],
                                      s_tdata[ple_pkg::OP_W + ple_pkg::POS_W +:
                                              ple_pkg::VAL_W]);
                replies_due.push_back(exp_r);
                if (exp_r.ok)
                    op_ok[op]++;
                else
                    op_bad[op]++;
                if (list_len > peak_len)
                    peak_len = list_len;
                s_held = 1'b0;
                n_taken++;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                got_r.ok  = m_tdata[0];
                got_r.rd  = m_tdata[ple_pkg::VAL_W:1];
                got_r.cnt = m_tdata[ple_pkg::VAL_W+ple_pkg::CNT_W:ple_pkg::VAL_W+1];
                n_replies++;
                idle_cycles = 0;
                if (replies_due.size() == 0) begin
                    flag_mismatch($sformatf("reply %0d with no request outstanding",
                                            n_replies));
                end else begin
                    exp_r = replies_due.pop_front();
                    if (got_r.ok !== exp_r.ok)
                        flag_mismatch($sformatf("reply %0d ok %b, want %b",
                                                n_replies, got_r.ok, exp_r.ok));
                    if (got_r.rd !== exp_r.rd)
                        flag_mismatch($sformatf("reply %0d read_value %h, want %h",
                                                n_replies, got_r.rd, exp_r.rd));
                    if (got_r.cnt !== exp_r.cnt)
                        flag_mismatch($sformatf("reply %0d count %0d, want %0d",
                                                n_replies, got_r.cnt, exp_r.cnt));
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t ns  no handshake for %0d cycles", $realtime, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int           k;
        int           roll;
        int           pick;
        ple_pkg::op_t op;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        s_held   = 1'b0;
        list_len = 0;
        plan_len = 0;
        foreach (list_mem[i])
            list_mem[i] = '0;

        // empty store, bad insert positions
        queue_request(ple_pkg::OP_GET,    0,   '0);
        queue_request(ple_pkg::OP_REMOVE, 0,   '0);
        queue_request(ple_pkg::OP_SET,    0,   32'h1234_5678);
        queue_request(ple_pkg::OP_INSERT, 1,   32'h0000_0001);
        queue_request(ple_pkg::OP_INSERT, 127, 32'h0000_0002);
        // build at front, back and middle with extreme values
        queue_request(ple_pkg::OP_INSERT, 0,   32'h8000_0000);
        queue_request(ple_pkg::OP_INSERT, 1,   32'h7FFF_FFFF);
        queue_request(ple_pkg::OP_INSERT, 0,   32'hFFFF_FFFF);
        queue_request(ple_pkg::OP_INSERT, 3,   32'h0000_0000);
        queue_request(ple_pkg::OP_INSERT, 1,   32'h0000_0001);
        queue_request(ple_pkg::OP_GET,    0,   '0);
        queue_request(ple_pkg::OP_GET,    4,   '0);
        queue_request(ple_pkg::OP_GET,    5,   '0);
        queue_request(ple_pkg::OP_GET,    64,  '0);
        queue_request(ple_pkg::OP_GET,    127, '0);
        // set at count is refused
        queue_request(ple_pkg::OP_SET,    4,   32'h5555_5555);
        queue_request(ple_pkg::OP_SET,    5,   32'hDEAD_BEEF);
        queue_request(ple_pkg::OP_SET,    0,   32'hAAAA_AAAA);
        queue_request(ple_pkg::OP_REMOVE, 4,   '0);
        queue_request(ple_pkg::OP_REMOVE, 0,   '0);
        queue_request(ple_pkg::OP_REMOVE, 3,   '0);
        queue_request(ple_pkg::OP_GET,    1,   '0);
        queue_request(ple_pkg::OP_GET,    2,   '0);

        // fill, drain and mixed phases so that both full and empty are hit
        for (k = 0; k < N_RANDOM; k++) begin
            roll = $urandom_range(0, 99);
            case ((k / 150) % 3)
                0: op = (roll < 65) ? ple_pkg::OP_INSERT
                                    : ple_pkg::op_t'(2'($urandom_range(1, 3)));
                1: begin
                    pick = $urandom_range(0, 2);
                    op = (roll < 65) ? ple_pkg::OP_REMOVE :
                         (pick == 0) ? ple_pkg::OP_INSERT : ple_pkg::op_t'(2'(pick + 1));
                end
                default: op = ple_pkg::op_t'(2'($urandom_range(0, 3)));
            endcase
            queue_request(op, pick_position(op), pick_value());
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() > 0 || s_held)
            @(posedge aclk);
        while (replies_due.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d requests, %0d replies; ok/refused: insert %0d/%0d, remove %0d/%0d,",
                 n_taken, n_replies, op_ok[ple_pkg::OP_INSERT], op_bad[ple_pkg::OP_INSERT],
                 op_ok[ple_pkg::OP_REMOVE], op_bad[ple_pkg::OP_REMOVE]);
        $display("get %0d/%0d, set %0d/%0d", op_ok[ple_pkg::OP_GET], op_bad[ple_pkg::OP_GET],
                 op_ok[ple_pkg::OP_SET], op_bad[ple_pkg::OP_SET]);
        $display("list peaked at %0d entries, %0d inserts refused when full, %0d mismatches",
                 peak_len, full_rejects, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
